// ===== rtl/bci_pkg.sv =====
// Shared definitions for the iterative binomial coefficient core:
// microcode step addresses, operation and jump codes, control word and flag types.
// No dependencies.
`timescale 1ns / 1ps

package bci_pkg;

	localparam int NW      = 6;
	localparam int VALUE_W = 59;
	localparam int STAT_W  = 2;
	localparam int RES_W   = 64;
	localparam int REM_W   = 6;
	localparam int CNT_W   = 6;
	localparam int MAX_N_DEF = 62;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_K_GT_N = 2'd1;
	localparam logic [STAT_W-1:0] ST_N_BIG = 2'd2;

	typedef logic [2:0] upc_t;

	localparam upc_t PC_IDLE  = 3'd0;
	localparam upc_t PC_CHECK = 3'd1;
	localparam upc_t PC_PREP  = 3'd2;
	localparam upc_t PC_TEST  = 3'd3;
	localparam upc_t PC_MUL   = 3'd4;
	localparam upc_t PC_DSTEP = 3'd5;
	localparam upc_t PC_INC   = 3'd6;
	localparam upc_t PC_EMIT  = 3'd7;

	typedef logic [2:0] op_t;

	localparam op_t OP_NONE  = 3'd0;
	localparam op_t OP_LOAD  = 3'd1;
	localparam op_t OP_PREP  = 3'd2;
	localparam op_t OP_MUL   = 3'd3;
	localparam op_t OP_DSTEP = 3'd4;
	localparam op_t OP_INC   = 3'd5;
	localparam op_t OP_EMIT  = 3'd6;

	typedef logic [2:0] cnd_t;

	localparam cnd_t CND_NEVER     = 3'd0;
	localparam cnd_t CND_ALWAYS    = 3'd1;
	localparam cnd_t CND_NO_INPUT  = 3'd2;
	localparam cnd_t CND_ERR       = 3'd3;
	localparam cnd_t CND_LOOP_DONE = 3'd4;
	localparam cnd_t CND_CNT_NZ    = 3'd5;
	localparam cnd_t CND_OUT_FULL  = 3'd6;

	typedef struct packed {
		op_t  op;
		cnd_t cnd;
		upc_t target;
	} ctrl_t;

	typedef struct packed {
		logic err;
		logic loop_done;
		logic cnt_nz;
	} dp_flags_t;

	typedef struct packed {
		logic      no_input;
		logic      out_full;
		dp_flags_t dp;
	} flags_t;

	function automatic ctrl_t ucode(input upc_t pc);
		ctrl_t w;
		case (pc)
			PC_IDLE:  w = '{op: OP_LOAD,  cnd: CND_NO_INPUT,  target: PC_IDLE};
			PC_CHECK: w = '{op: OP_NONE,  cnd: CND_ERR,       target: PC_EMIT};
			PC_PREP:  w = '{op: OP_PREP,  cnd: CND_NEVER,     target: PC_IDLE};
			PC_TEST:  w = '{op: OP_NONE,  cnd: CND_LOOP_DONE, target: PC_EMIT};
			PC_MUL:   w = '{op: OP_MUL,   cnd: CND_NEVER,     target: PC_IDLE};
			PC_DSTEP: w = '{op: OP_DSTEP, cnd: CND_CNT_NZ,    target: PC_DSTEP};
			PC_INC:   w = '{op: OP_INC,   cnd: CND_ALWAYS,    target: PC_TEST};
			PC_EMIT:  w = '{op: OP_EMIT,  cnd: CND_OUT_FULL,  target: PC_EMIT};
			default:  w = '{op: OP_NONE,  cnd: CND_ALWAYS,    target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/bci_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on bci_pkg.
`timescale 1ns / 1ps

module bci_sequencer import bci_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	upc_t upc_q;
	logic take;

	assign ctrl = ucode(upc_q);

	always_comb begin
		case (ctrl.cnd)
			CND_NEVER:     take = 1'b0;
			CND_ALWAYS:    take = 1'b1;
			CND_NO_INPUT:  take = flags.no_input;
			CND_ERR:       take = flags.dp.err;
			CND_LOOP_DONE: take = flags.dp.loop_done;
			CND_CNT_NZ:    take = flags.dp.cnt_nz;
			CND_OUT_FULL:  take = flags.out_full;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= PC_IDLE;
		end else if (take) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + upc_t'(1);
		end
	end

endmodule

// ===== rtl/bci_datapath.sv =====
// Datapath: operand registers, 64-bit product register, multiply by a small
// factor and a one-bit-per-cycle restoring divider. Depends on bci_pkg.
`timescale 1ns / 1ps

module bci_datapath import bci_pkg::*; #(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic              clk,
	input  ctrl_t             ctrl,
	input  logic              in_valid,
	input  logic [NW-1:0]     n,
	input  logic [NW-1:0]     k,
	output dp_flags_t         dp_flags,
	output logic [VALUE_W-1:0] value,
	output logic [STAT_W-1:0] status
);

	localparam logic [NW-1:0] MaxN = NW'(MAX_N);

	logic [NW-1:0]     n_q;
	logic [NW-1:0]     k_q;
	logic [NW-1:0]     kk_q;
	logic [NW-1:0]     i_q;
	logic [RES_W-1:0]  res_q;
	logic [REM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STAT_W-1:0] status_q;

	logic [NW-1:0]       n_minus_k;
	logic [NW:0]         factor;
	logic [RES_W+NW:0]   product;
	logic [REM_W:0]      sh;
	logic                ge;
	logic [REM_W:0]      diff;

	assign n_minus_k = n_q - k_q;
	assign factor    = {1'b0, n_q - kk_q} + {1'b0, i_q};
	assign product   = res_q * factor;
	assign sh        = {rem_q, res_q[RES_W-1]};
	assign ge        = sh >= {1'b0, i_q};
	assign diff      = sh - {1'b0, i_q};

	assign dp_flags.err       = status_q != ST_OK;
	assign dp_flags.loop_done = i_q > kk_q;
	assign dp_flags.cnt_nz    = cnt_q != '0;

	assign status = status_q;
	assign value  = (status_q != ST_OK) ? '0 : res_q[VALUE_W-1:0];

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_valid) begin
					n_q <= n;
					k_q <= k;
					if (k > n) begin
						status_q <= ST_K_GT_N;
					end else if (n > MaxN) begin
						status_q <= ST_N_BIG;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			OP_PREP: begin
				kk_q  <= (k_q > n_minus_k) ? n_minus_k : k_q;
				i_q   <= NW'(1);
				res_q <= RES_W'(1);
			end
			OP_MUL: begin
				res_q <= product[RES_W-1:0];
				rem_q <= '0;
				cnt_q <= '1;
			end
			OP_DSTEP: begin
				res_q <= {res_q[RES_W-2:0], ge};
				rem_q <= ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_INC: begin
				i_q <= i_q + NW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/binomial_coefficient_iterative_core.sv =====
// Top level of the iterative binomial coefficient core: stream ports, output
// register and the link between sequencer and datapath.
// Depends on bci_pkg, bci_sequencer and bci_datapath.
//
// Usage: present n and k on the slave stream; one transfer yields exactly one
// result transfer on the master stream carrying C(n,k) (zero on an error) and a status code.
// The core takes one item at a time. Each loop pass, repeated min(k, n-k)
// times, is a test, one multiply, a divider step per result bit and a counter
// step on the shared datapath; the result is then loaded into the output
// register. Out-of-range operands skip the loop.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls with a result still held, the sequencer
// holds at its final step until that transfer completes.
// Reset clears the step counter and the output valid; no other state is kept.
`timescale 1ns / 1ps

module binomial_coefficient_iterative_core import bci_pkg::*; #(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] n, [11:6] k, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [58:0] value, [63:59] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	ctrl_t                ctrl;
	flags_t               flags;
	dp_flags_t            dp_flags;
	logic [VALUE_W-1:0]   dp_value;
	logic [STAT_W-1:0]    dp_status;

	logic                 m_tvalid_q;
	logic [VALUE_W-1:0]   value_q;
	logic [STAT_W-1:0]    status_q;
	logic                 out_full;

	assign out_full       = m_tvalid_q & ~m_tready;
	assign flags.no_input = ~s_tvalid;
	assign flags.out_full = out_full;
	assign flags.dp       = dp_flags;

	assign s_tready = ctrl.op == OP_LOAD;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(64-VALUE_W){1'b0}}, value_q};
	assign m_tuser  = status_q;

	bci_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	bci_datapath #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk      (clk),
		.ctrl     (ctrl),
		.in_valid (s_tvalid),
		.n        (s_tdata[5:0]),
		.k        (s_tdata[11:6]),
		.dp_flags (dp_flags),
		.value    (dp_value),
		.status   (dp_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT && !out_full) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT && !out_full) begin
			value_q  <= dp_value;
			status_q <= dp_status;
		end
	end

endmodule
